FILE: hw/rtl/four_quadrant_arctangent_macros.svh
// Assertion macros used by the checker file.
`ifndef FOUR_QUADRANT_ARCTANGENT_MACROS_SVH
`define FOUR_QUADRANT_ARCTANGENT_MACROS_SVH

// Checked at every rising edge outside reset.
`define FQA_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define FQA_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: hw/rtl/fqa_pkg.sv
`timescale 1ns / 1ps

package fqa_pkg;

   // Default widths of the fields
   localparam int INPUT_BITS_DEF      = 16;
   localparam int ANGLE_FRAC_BITS_DEF = 13;

   // Datapath: magnitudes are normalized into [2^54, 2^55); x grows by the CORDIC gain
   localparam int DATA_W      = 58;
   localparam int NORM_TOP    = 55;
   localparam int NORM_STAGES = 6;
   localparam int STEP_COUNT  = 30;

   // Angle accumulator in Q2.30
   localparam int Z_W = 33;
   localparam int T_W = 31;
   localparam logic [T_W-1:0] HALF_PI_Q30 = 31'h6487ED51;
   localparam logic [63:0]    PI_Q60      = 64'h3243F6A8885A308D;

   // Result kinds decided at the entry cell
   localparam int KIND_W = 3;
   localparam logic [KIND_W-1:0] KIND_VECTOR   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_ZERO     = 3'd1;
   localparam logic [KIND_W-1:0] KIND_POS_HALF = 3'd2;
   localparam logic [KIND_W-1:0] KIND_NEG_HALF = 3'd3;
   localparam logic [KIND_W-1:0] KIND_NEG_PI   = 3'd4;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              sine_neg;
      logic              cos_neg;
   } tag_type;

   // atan(2^-i) in Q2.30, truncated, except entries 27 to 29, which are rounded
   function automatic logic [T_W-1:0] atan_q30(input int idx);
      logic [T_W-1:0] t;
      case (idx)
         0:  t = 31'h3243F6A8;
         1:  t = 31'h1DAC6705;
         2:  t = 31'h0FADBAFC;
         3:  t = 31'h07F56EA6;
         4:  t = 31'h03FEAB76;
         5:  t = 31'h01FFD55B;
         6:  t = 31'h00FFFAAA;
         7:  t = 31'h007FFF55;
         8:  t = 31'h003FFFEA;
         9:  t = 31'h001FFFFD;
         10: t = 31'h000FFFFF;
         11: t = 31'h0007FFFF;
         12: t = 31'h0003FFFF;
         13: t = 31'h0001FFFF;
         14: t = 31'h0000FFFF;
         15: t = 31'h00007FFF;
         16: t = 31'h00003FFF;
         17: t = 31'h00001FFF;
         18: t = 31'h00000FFF;
         19: t = 31'h000007FF;
         20: t = 31'h000003FF;
         21: t = 31'h000001FF;
         22: t = 31'h000000FF;
         23: t = 31'h0000007F;
         24: t = 31'h0000003F;
         25: t = 31'h0000001F;
         26: t = 31'h0000000F;
         27: t = 31'h00000008;
         28: t = 31'h00000004;
         29: t = 31'h00000002;
         default: t = '0;
      endcase
      return t;
   endfunction

   // pi in Q60 rounded to nearest after a right shift by sh
   function automatic logic [63:0] round_pi(input int sh);
      logic [63:0] r;
      r = (PI_Q60 + (64'd1 << (sh - 1))) >> sh;
      return r;
   endfunction

endpackage

FILE: hw/rtl/four_quadrant_arctangent.sv
`timescale 1ns / 1ps
// Four-quadrant arctangent: angle of a (cosine, sine) pair in radians.
// Input channel req_: req_sine_value and req_cosine_value, signed Q1.15 at the
// default width; a transfer happens when req_valid and req_ready are both high.
// Result channel rsp_: rsp_angle, signed Q3.13 at the default width, from -pi
// to +pi; a transfer happens when rsp_valid and rsp_ready are both high.
// One result per input, in input order.
// Chain: one entry cell, six normalizing cells, thirty CORDIC vectoring
// cells and one exit cell, each registered.
// Throughput: one item per cycle while rsp_ready is high; each cell of the
// chain holds one item.
// Stall: every cell moves forward when its successor has room, so a stalled
// receiver fills the chain from the output end; req_ready drops only once all
// 38 cells hold an item. rsp_angle stays put while rsp_valid waits.
// Reset (synchronous, active high) empties the chain; rsp_valid is low after it.
// Zero cosine returns +-pi/2, zero sine with negative cosine returns -pi, and
// zero for both returns 0.

module four_quadrant_arctangent #(
   parameter int INPUT_BITS      = fqa_pkg::INPUT_BITS_DEF,
   parameter int ANGLE_FRAC_BITS = fqa_pkg::ANGLE_FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [INPUT_BITS-1:0]       req_sine_value,
   input  logic signed [INPUT_BITS-1:0]       req_cosine_value,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [ANGLE_FRAC_BITS+2:0]  rsp_angle
);

   localparam int NS = fqa_pkg::NORM_STAGES;
   localparam int CS = fqa_pkg::STEP_COUNT;

   logic                              norm_valid [NS+1];
   logic                              norm_ready [NS+1];
   logic [fqa_pkg::DATA_W-1:0]        norm_x     [NS+1];
   logic [fqa_pkg::DATA_W-1:0]        norm_y     [NS+1];
   fqa_pkg::tag_type                  norm_tag   [NS+1];

   logic                              cord_valid [CS+1];
   logic                              cord_ready [CS+1];
   logic [fqa_pkg::DATA_W-1:0]        cord_x     [CS+1];
   logic [fqa_pkg::DATA_W-1:0]        cord_y     [CS+1];
   logic signed [fqa_pkg::Z_W-1:0]    cord_z     [CS+1];
   fqa_pkg::tag_type                  cord_tag   [CS+1];

   // Input decode
   fqa_entry_cell #(.INPUT_BITS(INPUT_BITS)) u_entry (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_valid),
      .in_ready     (req_ready),
      .sine_value   (req_sine_value),
      .cosine_value (req_cosine_value),
      .out_valid    (norm_valid[0]),
      .out_ready    (norm_ready[0]),
      .out_x        (norm_x[0]),
      .out_y        (norm_y[0]),
      .out_tag      (norm_tag[0])
   );

   // Normalizing cells, shifts of 32, 16, 8, 4, 2, 1
   for (genvar k = 0; k < NS; k++) begin : g_norm
      fqa_norm_cell #(.SHIFT(1 << (NS - 1 - k))) u_norm (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (norm_valid[k]),
         .in_ready  (norm_ready[k]),
         .in_x      (norm_x[k]),
         .in_y      (norm_y[k]),
         .in_tag    (norm_tag[k]),
         .out_valid (norm_valid[k+1]),
         .out_ready (norm_ready[k+1]),
         .out_x     (norm_x[k+1]),
         .out_y     (norm_y[k+1]),
         .out_tag   (norm_tag[k+1])
      );
   end

   // Hand over from the normalizer to the rotation chain
   assign cord_valid[0]  = norm_valid[NS];
   assign norm_ready[NS] = cord_ready[0];
   assign cord_x[0]      = norm_x[NS];
   assign cord_y[0]      = norm_y[NS];
   assign cord_z[0]      = '0;
   assign cord_tag[0]    = norm_tag[NS];

   // Vectoring cells, one per CORDIC step
   for (genvar i = 0; i < CS; i++) begin : g_cord
      fqa_cordic_cell #(.IDX(i)) u_cord (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (cord_valid[i]),
         .in_ready  (cord_ready[i]),
         .in_x      (cord_x[i]),
         .in_y      (cord_y[i]),
         .in_z      (cord_z[i]),
         .in_tag    (cord_tag[i]),
         .out_valid (cord_valid[i+1]),
         .out_ready (cord_ready[i+1]),
         .out_x     (cord_x[i+1]),
         .out_y     (cord_y[i+1]),
         .out_z     (cord_z[i+1]),
         .out_tag   (cord_tag[i+1])
      );
   end

   // Quadrant placement and output register; the final x and y are not needed
   fqa_exit_cell #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_exit (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cord_valid[CS]),
      .in_ready  (cord_ready[CS]),
      .in_z      (cord_z[CS]),
      .in_tag    (cord_tag[CS]),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_angle (rsp_angle)
   );

endmodule

FILE: hw/rtl/fqa_entry_cell.sv
`timescale 1ns / 1ps

module fqa_entry_cell #(
   parameter int INPUT_BITS = fqa_pkg::INPUT_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  logic signed [INPUT_BITS-1:0]     sine_value,
   input  logic signed [INPUT_BITS-1:0]     cosine_value,
   output logic                             out_valid,
   input  logic                             out_ready,
   output logic [fqa_pkg::DATA_W-1:0]       out_x,
   output logic [fqa_pkg::DATA_W-1:0]       out_y,
   output fqa_pkg::tag_type                 out_tag
);

   logic                        valid_ff, valid_in;
   logic [fqa_pkg::DATA_W-1:0]  x_ff, x_in, y_ff, y_in;
   fqa_pkg::tag_type            tag_ff, tag_in;
   logic [INPUT_BITS-1:0]       s_mag, c_mag;
   logic                        s_zero, c_zero;

   assign in_ready = !valid_ff || out_ready;

   // Magnitudes and special-case classification
   always_comb begin
      s_mag  = sine_value[INPUT_BITS-1] ? (~sine_value + 1'b1) : sine_value;
      c_mag  = cosine_value[INPUT_BITS-1] ? (~cosine_value + 1'b1) : cosine_value;
      s_zero = (sine_value == '0);
      c_zero = (cosine_value == '0);
      tag_in.sine_neg = sine_value[INPUT_BITS-1];
      tag_in.cos_neg  = cosine_value[INPUT_BITS-1];
      if (c_zero) begin
         if (s_zero) tag_in.kind = fqa_pkg::KIND_ZERO;
         else if (sine_value[INPUT_BITS-1]) tag_in.kind = fqa_pkg::KIND_NEG_HALF;
         else tag_in.kind = fqa_pkg::KIND_POS_HALF;
      end else if (s_zero) begin
         tag_in.kind = cosine_value[INPUT_BITS-1] ? fqa_pkg::KIND_NEG_PI : fqa_pkg::KIND_ZERO;
      end else begin
         tag_in.kind = fqa_pkg::KIND_VECTOR;
      end
      x_in     = fqa_pkg::DATA_W'(c_mag);
      y_in     = fqa_pkg::DATA_W'(s_mag);
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         x_ff   <= x_in;
         y_ff   <= y_in;
         tag_ff <= tag_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_tag   = tag_ff;

endmodule

FILE: hw/rtl/fqa_norm_cell.sv
`timescale 1ns / 1ps

module fqa_norm_cell #(
   parameter int SHIFT = 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [fqa_pkg::DATA_W-1:0]  in_x,
   input  logic [fqa_pkg::DATA_W-1:0]  in_y,
   input  fqa_pkg::tag_type            in_tag,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic [fqa_pkg::DATA_W-1:0]  out_x,
   output logic [fqa_pkg::DATA_W-1:0]  out_y,
   output fqa_pkg::tag_type            out_tag
);

   logic                        valid_ff, valid_in;
   logic [fqa_pkg::DATA_W-1:0]  x_ff, x_in, y_ff, y_in;
   fqa_pkg::tag_type            tag_ff;
   logic                        room;

   assign in_ready = !valid_ff || out_ready;

   // Shift both by SHIFT when the larger one stays below 2^55 afterwards
   always_comb begin
      room = ((in_x >> (fqa_pkg::NORM_TOP - SHIFT)) == '0) &&
             ((in_y >> (fqa_pkg::NORM_TOP - SHIFT)) == '0);
      x_in = room ? (in_x << SHIFT) : in_x;
      y_in = room ? (in_y << SHIFT) : in_y;
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         x_ff   <= x_in;
         y_ff   <= y_in;
         tag_ff <= in_tag;
      end
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_tag   = tag_ff;

endmodule

FILE: hw/rtl/fqa_cordic_cell.sv
`timescale 1ns / 1ps

module fqa_cordic_cell #(
   parameter int IDX = 0
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  logic [fqa_pkg::DATA_W-1:0]       in_x,
   input  logic [fqa_pkg::DATA_W-1:0]       in_y,
   input  logic signed [fqa_pkg::Z_W-1:0]   in_z,
   input  fqa_pkg::tag_type                 in_tag,
   output logic                             out_valid,
   input  logic                             out_ready,
   output logic [fqa_pkg::DATA_W-1:0]       out_x,
   output logic [fqa_pkg::DATA_W-1:0]       out_y,
   output logic signed [fqa_pkg::Z_W-1:0]   out_z,
   output fqa_pkg::tag_type                 out_tag
);

   localparam logic [fqa_pkg::Z_W-1:0] Step = fqa_pkg::Z_W'(fqa_pkg::atan_q30(IDX));

   logic                               valid_ff, valid_in;
   logic [fqa_pkg::DATA_W-1:0]         x_ff, x_in, y_ff, y_in;
   logic signed [fqa_pkg::Z_W-1:0]     z_ff, z_in;
   fqa_pkg::tag_type                   tag_ff;
   logic signed [fqa_pkg::DATA_W-1:0]  xs, ys, dx, dy;

   assign in_ready = !valid_ff || out_ready;

   // One vectoring rotation, driven by the sign of y
   always_comb begin
      xs = $signed(in_x);
      ys = $signed(in_y);
      dx = ys >>> IDX;
      dy = xs >>> IDX;
      if (!ys[fqa_pkg::DATA_W-1]) begin
         x_in = xs + dx;
         y_in = ys - dy;
         z_in = in_z + $signed(Step);
      end else begin
         x_in = xs - dx;
         y_in = ys + dy;
         z_in = in_z - $signed(Step);
      end
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         x_ff   <= x_in;
         y_ff   <= y_in;
         z_ff   <= z_in;
         tag_ff <= in_tag;
      end
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;
   assign out_tag   = tag_ff;

endmodule

FILE: hw/rtl/fqa_exit_cell.sv
`timescale 1ns / 1ps

module fqa_exit_cell #(
   parameter int ANGLE_FRAC_BITS = fqa_pkg::ANGLE_FRAC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  logic signed [fqa_pkg::Z_W-1:0]   in_z,
   input  fqa_pkg::tag_type                 in_tag,
   output logic                             out_valid,
   input  logic                             out_ready,
   output logic signed [ANGLE_FRAC_BITS+2:0] out_angle
);

   localparam int AW = ANGLE_FRAC_BITS + 3;
   localparam logic [63:0]   PiWide   = fqa_pkg::round_pi(60 - ANGLE_FRAC_BITS);
   localparam logic [63:0]   HalfWide = fqa_pkg::round_pi(61 - ANGLE_FRAC_BITS);
   localparam logic [AW-1:0] PiF      = PiWide[AW-1:0];
   localparam logic [AW-1:0] HalfF    = HalfWide[AW-1:0];
   localparam logic [fqa_pkg::T_W:0] Rnd = (fqa_pkg::T_W + 1)'(1) << (29 - ANGLE_FRAC_BITS);

   logic                        valid_ff, valid_in;
   logic [AW-1:0]               angle_ff, angle_in;
   logic [fqa_pkg::Z_W-2:0]     z_pos;
   logic [fqa_pkg::T_W-1:0]     z_cl;
   logic [fqa_pkg::T_W:0]       z_sum, theta_wide;
   logic [AW-1:0]               theta;

   assign in_ready = !valid_ff || out_ready;

   // Clamp to [0, pi/2], round to the output scale, place in the quadrant; special kinds take fixed angles
   always_comb begin
      z_pos = in_z[fqa_pkg::Z_W-2:0];
      if (in_z[fqa_pkg::Z_W-1]) z_cl = '0;
      else if (z_pos > (fqa_pkg::Z_W - 1)'(fqa_pkg::HALF_PI_Q30)) z_cl = fqa_pkg::HALF_PI_Q30;
      else z_cl = z_pos[fqa_pkg::T_W-1:0];
      z_sum      = {1'b0, z_cl} + Rnd;
      theta_wide = z_sum >> (30 - ANGLE_FRAC_BITS);
      theta      = theta_wide[AW-1:0];
      case (in_tag.kind)
         fqa_pkg::KIND_VECTOR: begin
            if (in_tag.cos_neg) angle_in = in_tag.sine_neg ? (theta - PiF) : (PiF - theta);
            else angle_in = in_tag.sine_neg ? (~theta + 1'b1) : theta;
         end
         fqa_pkg::KIND_POS_HALF: angle_in = HalfF;
         fqa_pkg::KIND_NEG_HALF: angle_in = ~HalfF + 1'b1;
         fqa_pkg::KIND_NEG_PI:   angle_in = ~PiF + 1'b1;
         default:                angle_in = '0;
      endcase
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) angle_ff <= angle_in;
   end

   assign out_valid = valid_ff;
   assign out_angle = angle_ff;

endmodule

FILE: hw/rtl/fqa_checker.sv
`timescale 1ns / 1ps
`include "four_quadrant_arctangent_macros.svh"

module fqa_checker #(
   parameter int INPUT_BITS      = fqa_pkg::INPUT_BITS_DEF,
   parameter int ANGLE_FRAC_BITS = fqa_pkg::ANGLE_FRAC_BITS_DEF
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic signed [INPUT_BITS-1:0]       req_sine_value,
   input logic signed [INPUT_BITS-1:0]       req_cosine_value,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [ANGLE_FRAC_BITS+2:0]  rsp_angle
);

   localparam int AW = ANGLE_FRAC_BITS + 3;
   localparam logic [63:0] PiWide = fqa_pkg::round_pi(60 - ANGLE_FRAC_BITS);
   localparam logic signed [AW:0] PiHi = $signed({1'b0, PiWide[AW-1:0]});
   localparam logic signed [AW:0] PiLo = -PiHi;

   logic signed [AW:0]          angle_x;
   logic [2*INPUT_BITS-1:0]     req_payload;
   logic                        req_wait, rsp_wait;

   assign angle_x     = {rsp_angle[AW-1], rsp_angle};
   assign req_payload = {req_sine_value, req_cosine_value};
   assign req_wait    = req_valid && !req_ready;
   assign rsp_wait    = rsp_valid && !rsp_ready;

   // A stalled transfer stays offered and unchanged on both channels
   `FQA_ASSERT(a_req_hold, req_wait |=> req_valid && $stable(req_payload), "stalled req changed")
   `FQA_ASSERT(a_rsp_hold, rsp_wait |=> rsp_valid && $stable(rsp_angle), "stalled rsp changed")
   // Every angle lies within minus pi to plus pi
   `FQA_ASSERT(a_angle_range, rsp_valid |-> (angle_x <= PiHi) && (angle_x >= PiLo), "angle out of range")
   // Reset empties the chain; an empty output cell means the chain takes input
   `FQA_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "rsp_valid high after reset")
   `FQA_ASSERT(a_ready_when_drained, !rsp_valid |-> req_ready, "req_ready low with room")

endmodule

bind four_quadrant_arctangent fqa_checker #(
   .INPUT_BITS      (INPUT_BITS),
   .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
) u_fqa_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_sine_value   (req_sine_value),
   .req_cosine_value (req_cosine_value),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_angle        (rsp_angle)
);
